@@ design/bpsc_pkg.sv @@
// bpsc_pkg: payload types, cell control and link structs, and key constants
// for the bst preorder stream checker; no dependencies
package bpsc_pkg;

    localparam int KEY_W = 32;

    localparam logic signed [KEY_W-1:0] INT_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    end_of_sequence;
    } t_bpsc_in;

    typedef struct packed {
        logic still_valid;
        logic stack_overflowed;
        logic final_verdict;
    } t_bpsc_out;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic upd;
        logic clr;
    } t_bpsc_ctl;

    // handed from a cell to the one above it
    typedef struct packed {
        logic keep;
    } t_bpsc_link;

    // what each cell reports back to the top level
    typedef struct packed {
        logic                    occupied;
        logic                    boundary;
        logic signed [KEY_W-1:0] cand;
    } t_bpsc_tap;

endpackage

@@ design/bpsc_cell.sv @@
// bpsc_cell: one stack slot of the checker, holds a key and an occupied bit
// depends on bpsc_pkg
module bpsc_cell
    import bpsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_bpsc_ctl               i_ctl,
    input  logic signed [KEY_W-1:0] i_key,
    input  t_bpsc_link              i_below,
    output t_bpsc_link              o_above,
    output t_bpsc_tap               o_tap
);

    logic                    r_occ;
    logic signed [KEY_W-1:0] r_key;
    logic                    pop;
    logic                    keep;
    logic                    push;

    // stacked keys smaller than the new key leave together
    assign pop  = r_occ && (r_key < i_key);
    assign keep = r_occ && !pop;
    // new key lands in the lowest slot that is free after popping
    assign push = i_below.keep && !keep;

    assign o_above.keep   = keep;
    assign o_tap.occupied = r_occ;
    // deepest popped slot sets the new bound
    assign o_tap.boundary = pop && i_below.keep;
    assign o_tap.cand     = (pop && i_below.keep) ? r_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.clr) begin
            r_occ <= 1'b0;
        end else if (i_ctl.upd) begin
            r_occ <= keep || push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && push) begin
            r_key <= i_key;
        end
    end

endmodule

@@ design/bst_preorder_stream_checker.sv @@
// channel   valid         stall         payload
// input     i_in_valid    o_in_stall    i_in_data  (t_bpsc_in)
// output    o_out_valid   i_out_stall   o_out_data (t_bpsc_out)
//
// one request per cycle while the input is not stalled; the result appears in the cycle after acceptance
// all slots compare against the new key at once, so pops never iterate
// the longest path is a slot compare plus the or-tree that picks the new bound
// synchronous active-low reset empties the stack and clears both flags
// a stalled output holds its result; input stalls only while that result waits
// bst_preorder_stream_checker: top level, a row of bpsc_cell slots plus bound
// and sticky flags; depends on bpsc_pkg and bpsc_cell
module bst_preorder_stream_checker
    import bpsc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_bpsc_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_bpsc_out o_out_data
);

    logic                    r_failed;
    logic                    r_ovf;
    logic signed [KEY_W-1:0] r_bound;
    logic                    r_out_valid;
    t_bpsc_out               r_out_data;

    logic                    n_failed;
    logic                    n_ovf;
    logic signed [KEY_W-1:0] n_bound;

    logic                    accept;
    logic                    below;
    logic                    ok;
    logic                    full;
    logic                    any_pop;
    logic signed [KEY_W-1:0] cand;
    logic [STACK_DEPTH-1:0]  occ;
    t_bpsc_ctl               ctl;
    t_bpsc_link              link [STACK_DEPTH+1];
    t_bpsc_tap               tap  [STACK_DEPTH];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign link[0].keep = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            bpsc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_key   (i_in_data.key_value),
                .i_below (link[gi]),
                .o_above (link[gi+1]),
                .o_tap   (tap[gi])
            );
            assign occ[gi] = tap[gi].occupied;
        end
    endgenerate

    always_comb begin
        cand    = '0;
        any_pop = 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            cand    = cand | tap[k].cand;
            any_pop = any_pop | tap[k].boundary;
        end
    end

    assign below = i_in_data.key_value < r_bound;
    assign ok    = !r_failed && !below;
    // every slot kept after popping: no room for the new key
    assign full  = link[STACK_DEPTH].keep;

    assign ctl.upd = accept && ok && !full;
    assign ctl.clr = accept && i_in_data.end_of_sequence;

    always_comb begin
        n_failed = r_failed || below || full;
        n_ovf    = r_ovf || (ok && full);
        n_bound  = (ok && any_pop) ? cand : r_bound;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_bound     <= INT_MIN;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ctl.clr) begin
                r_failed <= 1'b0;
                r_ovf    <= 1'b0;
                r_bound  <= INT_MIN;
            end else if (accept) begin
                r_failed <= n_failed;
                r_ovf    <= n_ovf;
                r_bound  <= n_bound;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.still_valid      <= !n_failed;
            r_out_data.stack_overflowed <= n_ovf;
            r_out_data.final_verdict    <= i_in_data.end_of_sequence;
        end
    end

    // overflow always fails the sequence
    a_ovf_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_failed)
        else $error("overflow flag set without failure");

    // occupied slots form a contiguous run from the bottom
    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (occ & (occ + 1'b1)) == '0)
        else $error("stack occupancy has a hole");

    // end of sequence returns the flags, bound and stack to their reset values
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clr |=> (!r_failed && !r_ovf && r_bound == INT_MIN && occ == '0))
        else $error("state not cleared after end of sequence");

    // failure is sticky within a sequence
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !ctl.clr) |=> r_failed)
        else $error("failure dropped before end of sequence");

    // a failed sequence leaves the stack untouched
    a_fail_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !ctl.clr) |=> $stable(occ))
        else $error("stack changed after failure");

endmodule
